// File: rtl/core/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

	localparam int MODE_W   = 3;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_BACK   = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_READ       = 3'd4,
		MODE_WRITE      = 3'd5,
		MODE_INSERT     = 3'd6,
		MODE_ERASE      = 3'd7
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]    result_value;
		logic [COUNT_W-1:0]  element_count;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

// File: rtl/core/deq_stream_if.sv
// Valid/ready channel carrying one payload beat.
interface deq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// File: rtl/core/deq_seq.sv
// Request decoder and shift sequencer driving the ring store RAM.
module deq_seq #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	deq_stream_if.sink               req,
	output logic                     fin_valid,
	input  logic                     fin_ready,
	output deq_pkg::rsp_t            fin_data,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [DATA_WIDTH-1:0]    rd_data,
	output logic                     wr_en,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [DATA_WIDTH-1:0]    wr_data
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
	localparam int SW = LW + 1;

	typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_RESP} state_t;

	state_t              state_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       left_q;
	logic                vld_s1;
	logic [AW-1:0]       wr_slot_s1;
	logic [AW-1:0]       rd_slot_q;
	logic [AW-1:0]       tgt_slot_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic                ins_q;
	logic                rd_sel_q;
	deq_pkg::status_t    st_q;

	logic                acc;
	deq_pkg::mode_t      mode;
	deq_pkg::status_t    status_d;
	logic                ok;
	logic                full;
	logic                empty;
	logic [LW-1:0]       occ_l;
	logic [LW-1:0]       pos_l;
	logic [LW-1:0]       tgt_l;
	logic [LW-1:0]       sh_l;
	logic [CW-1:0]       sh_cnt;
	logic                is_shift;
	logic                rd_sel_d;
	logic                wr_sel_d;
	logic [AW-1:0]       tgt_slot;
	logic [DATA_WIDTH-1:0] val_in;
	logic [63:0]         rd_wide;

	// Logical position to store index; the depth is subtracted at most once.
	function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [LW-1:0] lg);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(lg);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return AW'(sum);
	endfunction

	function automatic logic [AW-1:0] slot_inc(logic [AW-1:0] s);
		return (s == AW'(DEPTH - 1)) ? '0 : AW'(s + 1'b1);
	endfunction

	function automatic logic [AW-1:0] slot_dec(logic [AW-1:0] s);
		return (s == '0) ? AW'(DEPTH - 1) : AW'(s - 1'b1);
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign mode      = deq_pkg::mode_t'(req.data.mode);
	assign occ_l     = LW'(occ_q);
	assign pos_l     = LW'(req.data.position);
	assign full      = (occ_q == CW'(DEPTH));
	assign empty     = (occ_q == '0);
	assign val_in    = DATA_WIDTH'(req.data.value);

	// Decode: status, target slot and shift extent of the incoming beat.
	always_comb begin
		status_d = deq_pkg::ST_OK;
		tgt_l    = pos_l;
		rd_sel_d = 1'b0;
		wr_sel_d = 1'b0;
		is_shift = 1'b0;
		sh_l     = pos_l + LW'(1);
		sh_cnt   = CW'(occ_l - pos_l - LW'(1));
		unique case (mode)
			deq_pkg::MODE_PUSH_BACK: begin
				if (full) status_d = deq_pkg::ST_FULL;
				tgt_l    = occ_l;
				wr_sel_d = 1'b1;
			end
			deq_pkg::MODE_PUSH_FRONT: begin
				if (full) status_d = deq_pkg::ST_FULL;
				wr_sel_d = 1'b1;
			end
			deq_pkg::MODE_POP_BACK: begin
				if (empty) status_d = deq_pkg::ST_EMPTY;
				tgt_l    = occ_l - LW'(1);
				rd_sel_d = 1'b1;
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (empty) status_d = deq_pkg::ST_EMPTY;
				tgt_l    = '0;
				rd_sel_d = 1'b1;
			end
			deq_pkg::MODE_READ: begin
				if (pos_l >= occ_l) status_d = deq_pkg::ST_RANGE;
				rd_sel_d = 1'b1;
			end
			deq_pkg::MODE_WRITE: begin
				if (pos_l >= occ_l) status_d = deq_pkg::ST_RANGE;
				wr_sel_d = 1'b1;
			end
			deq_pkg::MODE_INSERT: begin
				if (full) status_d = deq_pkg::ST_FULL;
				else if (pos_l > occ_l) status_d = deq_pkg::ST_RANGE;
				is_shift = 1'b1;
				sh_l     = occ_l - LW'(1);
				sh_cnt   = CW'(occ_l - pos_l);
			end
			deq_pkg::MODE_ERASE: begin
				if (pos_l >= occ_l) status_d = deq_pkg::ST_RANGE;
				is_shift = 1'b1;
			end
			default: status_d = deq_pkg::ST_RANGE;
		endcase
	end

	assign ok       = (status_d == deq_pkg::ST_OK);
	assign tgt_slot = (mode == deq_pkg::MODE_PUSH_FRONT) ? slot_dec(head_q)
		: slot_of(head_q, tgt_l);

	// RAM port steering.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_slot_q;
		wr_en   = 1'b0;
		wr_addr = tgt_slot_q;
		wr_data = val_q;
		unique case (state_q)
			S_IDLE: begin
				rd_addr = tgt_slot;
				wr_addr = tgt_slot;
				wr_data = val_in;
				rd_en   = acc && ok && rd_sel_d;
				wr_en   = acc && ok && wr_sel_d;
			end
			S_SHIFT: begin
				rd_en = (left_q != '0);
				if (vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = wr_slot_s1;
					wr_data = rd_data;
				end else if (left_q == '0 && ins_q) begin
					wr_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			left_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						left_q  <= (ok && is_shift) ? sh_cnt : '0;
						state_q <= (ok && is_shift) ? S_SHIFT : S_RESP;
						if (ok) begin
							unique case (mode)
								deq_pkg::MODE_PUSH_BACK,
								deq_pkg::MODE_INSERT: begin
									occ_q <= occ_q + CW'(1);
								end
								deq_pkg::MODE_PUSH_FRONT: begin
									occ_q  <= occ_q + CW'(1);
									head_q <= slot_dec(head_q);
								end
								deq_pkg::MODE_POP_FRONT: begin
									occ_q  <= occ_q - CW'(1);
									head_q <= slot_inc(head_q);
								end
								deq_pkg::MODE_POP_BACK,
								deq_pkg::MODE_ERASE: begin
									occ_q <= occ_q - CW'(1);
								end
								default: ;
							endcase
						end
					end
				end
				S_SHIFT: begin
					if (left_q != '0) begin
						left_q <= left_q - CW'(1);
						vld_s1 <= 1'b1;
					end else if (!vld_s1) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (fin_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: capture on accept, walk the read slot while shifting.
	always_ff @(posedge clk) begin
		if (acc) begin
			tgt_slot_q <= tgt_slot;
			rd_slot_q  <= slot_of(head_q, sh_l);
			val_q      <= val_in;
			ins_q      <= (mode == deq_pkg::MODE_INSERT);
			rd_sel_q   <= ok && rd_sel_d;
			st_q       <= status_d;
		end else if (state_q == S_SHIFT && left_q != '0) begin
			rd_slot_q  <= ins_q ? slot_dec(rd_slot_q) : slot_inc(rd_slot_q);
			wr_slot_s1 <= ins_q ? slot_inc(rd_slot_q) : slot_dec(rd_slot_q);
		end
	end

	assign rd_wide                = 64'(rd_data);
	assign fin_valid              = (state_q == S_RESP);
	assign fin_data.result_value  = rd_sel_q ? rd_wide[deq_pkg::VAL_W-1:0] : '0;
	assign fin_data.element_count = deq_pkg::COUNT_W'(occ_q);
	assign fin_data.status        = st_q;

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("read and write hit the same entry");

	a_fail_keeps_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && status_d != deq_pkg::ST_OK) |=> (occ_q == $past(occ_q)))
		else $error("failed request changed occupancy");
`endif
endmodule

// File: rtl/core/double_ended_queue_top.sv
// Top level of the double-ended queue: sequencer, ring store RAM, result register.
//
//  channel | dir | payload                              | accepted when
//  req     | in  | mode, position, value                | req.valid & req.ready
//  rsp     | out | result_value, element_count, status  | rsp.valid & rsp.ready
//
// Push, pop, read and write: a single read/write pass through the ring store RAM,
// whose read data is registered; no new request is taken until the result has gone to the output register.
// Insert and erase: a shift over the elements that must move; the shift streams one
// RAM read and one RAM write per cycle through one stage.
// Reset clears head, count and the control state; the store needs no clearing pass.
// A finished result waits in the output register while the next request runs.
module double_ended_queue_top #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	deq_stream_if.sink   req,
	deq_stream_if.source rsp
);
	localparam int AW = $clog2(DEPTH);

	logic                  fin_valid;
	logic                  fin_ready;
	deq_pkg::rsp_t         fin_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  rsp_valid_q;
	deq_pkg::rsp_t         rsp_data_q;

	// Decode requests, run the shift sequence, track head and count.
	deq_seq #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin_data  (fin_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// Ring store.
	deq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register: load a finished beat when empty or draining this cycle.
	assign fin_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_valid && fin_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload until the next beat replaces it.
	always_ff @(posedge clk) begin
		if (fin_valid && fin_ready) begin
			rsp_data_q <= fin_data;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

`ifndef NO_ASSERTIONS
	a_fail_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.status != deq_pkg::ST_OK) |-> (rsp.data.result_value == '0))
		else $error("failed request returned a value");
`endif
endmodule

// File: test/tb_top.sv
// Self-checking testbench for the double-ended queue against a shadow deque.
module tb_top;

	localparam int SLOTS        = 64;
	localparam int RANDOM_ITEMS = 1750;
	localparam int TAIL_CYCLES  = 100;     // longer than a full-length insert or erase shift
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int QUIET_TAIL   = 200;     // last beats on each side run without idling

	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} traffic_phase_t;

	logic clk;
	logic arst_n;

	deq_stream_if #(.payload_t(deq_pkg::req_t)) req_if ();
	deq_stream_if #(.payload_t(deq_pkg::rsp_t)) rsp_if ();

	double_ended_queue_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// Shadow deque: ring of slots, index of the front element and element count.
	logic [deq_pkg::VAL_W-1:0] shadow_slots [SLOTS];
	logic [5:0]                shadow_front;
	int                        shadow_held;
	int                        peak_held;

	deq_pkg::req_t pending_reqs [$];   // beats waiting for the driver
	deq_pkg::rsp_t expected_rsps [$];  // results owed by the block, oldest first

	int  total_reqs;
	int  beats_sent;
	int  rsps_seen;
	int  err_count;
	int  cycle_count;
	int  drain_a, drain_b;    // beat indexes at which the sender waits for all results
	int  status_seen [4];
	int  mode_seen [8];
	bit  req_taken;
	int  src_gap;
	int  sink_stall;

	// Map a logical position from the front onto a ring slot; the 6-bit sum wraps.
	function automatic logic [5:0] ring_slot(int k);
		return shadow_front + 6'(k);
	endfunction

	// Apply one request to the shadow deque and return the result it must produce.
	function automatic deq_pkg::rsp_t deque_apply(deq_pkg::req_t r);
		deq_pkg::rsp_t             o;
		int                        pos;
		logic [deq_pkg::VAL_W-1:0] val;
		pos = int'(r.position);
		val = r.value;
		o.result_value = '0;
		o.status       = deq_pkg::ST_OK;
		case (r.mode)
			deq_pkg::MODE_PUSH_BACK: begin
				if (shadow_held >= SLOTS) begin
					o.status = deq_pkg::ST_FULL;
				end else begin
					shadow_slots[ring_slot(shadow_held)] = val;
					shadow_held++;
				end
			end
			deq_pkg::MODE_PUSH_FRONT: begin
				if (shadow_held >= SLOTS) begin
					o.status = deq_pkg::ST_FULL;
				end else begin
					shadow_front = shadow_front - 6'd1;
					shadow_slots[shadow_front] = val;
					shadow_held++;
				end
			end
			deq_pkg::MODE_POP_BACK: begin
				if (shadow_held == 0) begin
					o.status = deq_pkg::ST_EMPTY;
				end else begin
					o.result_value = shadow_slots[ring_slot(shadow_held - 1)];
					shadow_held--;
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (shadow_held == 0) begin
					o.status = deq_pkg::ST_EMPTY;
				end else begin
					o.result_value = shadow_slots[shadow_front];
					shadow_front = shadow_front + 6'd1;
					shadow_held--;
				end
			end
			deq_pkg::MODE_READ: begin
				if (pos >= shadow_held)
					o.status = deq_pkg::ST_RANGE;
				else
					o.result_value = shadow_slots[ring_slot(pos)];
			end
			deq_pkg::MODE_WRITE: begin
				if (pos >= shadow_held)
					o.status = deq_pkg::ST_RANGE;
				else
					shadow_slots[ring_slot(pos)] = val;
			end
			deq_pkg::MODE_INSERT: begin
				// full is checked ahead of the position
				if (shadow_held >= SLOTS) begin
					o.status = deq_pkg::ST_FULL;
				end else if (pos > shadow_held) begin
					o.status = deq_pkg::ST_RANGE;
				end else begin
					for (int i = shadow_held; i > pos; i--)
						shadow_slots[ring_slot(i)] = shadow_slots[ring_slot(i - 1)];
					shadow_slots[ring_slot(pos)] = val;
					shadow_held++;
				end
			end
			default: begin
				// erase: move the later elements down, never touching past the last one
				if (pos >= shadow_held) begin
					o.status = deq_pkg::ST_RANGE;
				end else begin
					for (int i = pos; i + 1 < shadow_held; i++)
						shadow_slots[ring_slot(i)] = shadow_slots[ring_slot(i + 1)];
					shadow_held--;
				end
			end
		endcase
		o.element_count = deq_pkg::COUNT_W'(shadow_held);
		if (shadow_held > peak_held)
			peak_held = shadow_held;
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation. The generator keeps only a running element count
	// so that positions land mostly inside (or right at the edge of) the
	// occupied range; out-of-range and far positions are mixed in as noise.
	// ------------------------------------------------------------------
	int gen_held;

	task automatic queue_req(deq_pkg::mode_t m, int pos, logic [deq_pkg::VAL_W-1:0] val);
		deq_pkg::req_t r;
		r.mode     = m;
		r.position = deq_pkg::POS_W'(pos);
		r.value    = val;
		pending_reqs.insert(pending_reqs.size(), r);
		case (m)
			deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT:
				if (gen_held < SLOTS) gen_held++;
			deq_pkg::MODE_POP_BACK, deq_pkg::MODE_POP_FRONT:
				if (gen_held > 0) gen_held--;
			deq_pkg::MODE_INSERT:
				if (gen_held < SLOTS && pos <= gen_held) gen_held++;
			deq_pkg::MODE_ERASE:
				if (pos < gen_held) gen_held--;
			default: ;
		endcase
	endtask

	function automatic deq_pkg::mode_t pick_mode(traffic_phase_t ph);
		int r;
		r = $urandom_range(0, 99);
		case (ph)
			PH_FILL: begin
				if (r < 40) return deq_pkg::MODE_PUSH_BACK;
				if (r < 65) return deq_pkg::MODE_PUSH_FRONT;
				if (r < 80) return deq_pkg::MODE_INSERT;
				if (r < 85) return deq_pkg::MODE_WRITE;
				if (r < 90) return deq_pkg::MODE_READ;
				if (r < 95) return deq_pkg::MODE_POP_FRONT;
				return deq_pkg::MODE_ERASE;
			end
			PH_DRAIN: begin
				if (r < 35) return deq_pkg::MODE_POP_BACK;
				if (r < 60) return deq_pkg::MODE_POP_FRONT;
				if (r < 78) return deq_pkg::MODE_ERASE;
				if (r < 84) return deq_pkg::MODE_READ;
				if (r < 89) return deq_pkg::MODE_WRITE;
				if (r < 95) return deq_pkg::MODE_PUSH_BACK;
				return deq_pkg::MODE_INSERT;
			end
			default: return deq_pkg::mode_t'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic int pick_pos(deq_pkg::mode_t m, int held);
		int r;
		r = $urandom_range(0, 99);
		if (m inside {deq_pkg::MODE_PUSH_BACK, deq_pkg::MODE_PUSH_FRONT,
				deq_pkg::MODE_POP_BACK, deq_pkg::MODE_POP_FRONT})
			return $urandom_range(0, 127);   // ignored by these modes
		if (r < 6)
			return $urandom_range(0, 127);
		if (r < 14)
			return ($urandom_range(0, 1) != 0) ? held : held + 1;
		if (m == deq_pkg::MODE_INSERT)
			return $urandom_range(0, held);
		return (held == 0) ? 0 : $urandom_range(0, held - 1);
	endfunction

	function automatic logic [deq_pkg::VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return deq_pkg::VAL_W'($urandom);
	endfunction

	// Idling windows: every fourth block of 256 beats runs flat out, as does the tail.
	function automatic bit idle_allowed(int beat_idx);
		return (beat_idx < total_reqs - QUIET_TAIL) && (((beat_idx / 256) % 4) != 3);
	endfunction

	// ------------------------------------------------------------------
	// Clock, reset and the run itself.
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		traffic_phase_t ph;
		int             phase_left;
		deq_pkg::mode_t m;

		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.data   = '0;
		rsp_if.ready  = 1'b0;
		shadow_front  = '0;
		shadow_held   = 0;
		peak_held     = 0;
		gen_held      = 0;
		beats_sent    = 0;
		rsps_seen     = 0;
		err_count     = 0;
		cycle_count   = 0;
		req_taken     = 1'b0;
		src_gap       = 0;
		sink_stall    = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		foreach (mode_seen[i]) mode_seen[i] = 0;

		// Directed opener: empty-queue failures, edge positions, both ends, mid shifts.
		queue_req(deq_pkg::MODE_POP_BACK,   0, '0);
		queue_req(deq_pkg::MODE_POP_FRONT,  0, '0);
		queue_req(deq_pkg::MODE_READ,       0, '0);
		queue_req(deq_pkg::MODE_WRITE,      0, 32'hDEAD_BEEF);
		queue_req(deq_pkg::MODE_ERASE,      0, '0);
		queue_req(deq_pkg::MODE_INSERT,     1, 32'h1111_1111);   // past the count, empty queue
		queue_req(deq_pkg::MODE_INSERT,     0, '0);              // front of an empty queue
		queue_req(deq_pkg::MODE_PUSH_BACK,  127, '1);
		queue_req(deq_pkg::MODE_PUSH_FRONT, 64, 32'h1234_5678);
		queue_req(deq_pkg::MODE_READ,       127, '0);
		queue_req(deq_pkg::MODE_READ,       0, '0);
		queue_req(deq_pkg::MODE_READ,       2, '0);
		queue_req(deq_pkg::MODE_WRITE,      1, 32'hA5A5_A5A5);
		queue_req(deq_pkg::MODE_INSERT,     3, 32'h5A5A_5A5A);   // position equal to count appends
		queue_req(deq_pkg::MODE_INSERT,     1, 32'h0000_0001);
		queue_req(deq_pkg::MODE_ERASE,      4, '0);              // erase the last element
		queue_req(deq_pkg::MODE_ERASE,      0, '0);
		queue_req(deq_pkg::MODE_ERASE,      1, '0);
		queue_req(deq_pkg::MODE_READ,       64, '0);
		queue_req(deq_pkg::MODE_POP_BACK,   0, '0);
		queue_req(deq_pkg::MODE_POP_FRONT,  0, '0);
		queue_req(deq_pkg::MODE_POP_FRONT,  0, '0);
		drain_a = pending_reqs.size();

		// Random traffic in fill, drain and mixed phases so the queue swings
		// between empty and full and the wrap of the ring gets exercised.
		phase_left = 0;
		ph = PH_MIX;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: ph = PH_FILL;
					4, 5, 6:    ph = PH_DRAIN;
					default:    ph = PH_MIX;
				endcase
				phase_left = $urandom_range(60, 140);
			end
			phase_left--;
			m = pick_mode(ph);
			queue_req(m, pick_pos(m, gen_held), pick_value());
		end
		total_reqs = pending_reqs.size();
		drain_b = total_reqs / 2;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every beat to go in and every result to come back, then
		// give the block time to show any stray result.
		while (beats_sent < total_reqs || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests (push %0d/%0d, pop %0d/%0d, read %0d, write %0d,",
			rsps_seen, mode_seen[deq_pkg::MODE_PUSH_BACK], mode_seen[deq_pkg::MODE_PUSH_FRONT],
			mode_seen[deq_pkg::MODE_POP_BACK], mode_seen[deq_pkg::MODE_POP_FRONT],
			mode_seen[deq_pkg::MODE_READ], mode_seen[deq_pkg::MODE_WRITE]);
		$display("  insert %0d, erase %0d); ok %0d, full %0d, empty %0d, range %0d; peak %0d",
			mode_seen[deq_pkg::MODE_INSERT], mode_seen[deq_pkg::MODE_ERASE],
			status_seen[deq_pkg::ST_OK], status_seen[deq_pkg::ST_FULL],
			status_seen[deq_pkg::ST_EMPTY], status_seen[deq_pkg::ST_RANGE], peak_held);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: end the run once the cycle limit is reached, as when traffic stalls.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Request driver: change inputs on the falling edge only.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (req_if.valid && !req_taken) begin
			// hold the beat until the block takes it
		end else if (src_gap != 0) begin
			src_gap      <= src_gap - 1;
			req_if.valid <= 1'b0;
		end else if (req_taken && idle_allowed(beats_sent) && $urandom_range(0, 5) == 0) begin
			// open an idle burst; src_gap holds the rest of its random length
			src_gap      <= $urandom_range(0, 14);
			req_if.valid <= 1'b0;
		end else if (pending_reqs.size() == 0) begin
			req_if.valid <= 1'b0;
		end else if ((beats_sent == drain_a || beats_sent == drain_b)
				&& expected_rsps.size() != 0) begin
			// pause until every outstanding result has come back
			req_if.valid <= 1'b0;
		end else begin
			req_if.data  <= pending_reqs[0];
			req_if.valid <= 1'b1;
			pending_reqs.delete(0);
		end
	end

	// Result sink: stall in random bursts, never in the quiet windows.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (sink_stall != 0) begin
			sink_stall   <= sink_stall - 1;
			rsp_if.ready <= 1'b0;
		end else if (idle_allowed(rsps_seen) && $urandom_range(0, 9) == 0) begin
			sink_stall   <= $urandom_range(0, 14);
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge. Predict on each
	// accepted request beat, then check each accepted result beat against
	// the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		deq_pkg::rsp_t want;
		deq_pkg::rsp_t got;
		if (arst_n) begin
			req_taken <= req_if.valid && req_if.ready;
			if (req_if.valid && req_if.ready) begin
				want = deque_apply(req_if.data);
				expected_rsps.insert(expected_rsps.size(), want);
				mode_seen[req_if.data.mode]++;
				status_seen[want.status]++;
				beats_sent++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				rsps_seen++;
				if (expected_rsps.size() == 0) begin
					$error("result beat with nothing outstanding: value %0h count %0d status %0d",
						got.result_value, got.element_count, got.status);
					err_count++;
				end else begin
					want = expected_rsps[0];
					expected_rsps.delete(0);
					if (got.result_value !== want.result_value) begin
						$error("result_value: expected %0h, got %0h",
							want.result_value, got.result_value);
						err_count++;
					end
					if (got.element_count !== want.element_count) begin
						$error("element_count: expected %0d, got %0d",
							want.element_count, got.element_count);
						err_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						err_count++;
					end
				end
			end
		end else begin
			req_taken <= 1'b0;
		end
	end

endmodule

// File: files.f
rtl/core/deq_pkg.sv
rtl/core/deq_stream_if.sv
rtl/core/deq_ram.sv
rtl/core/deq_seq.sv
rtl/core/double_ended_queue_top.sv
test/tb_top.sv
